// ===== rtl/obbp_pkg.sv =====
// ----------------------------------------------------------------------------
// obbp_pkg: shared types and constants for the box/plane gap pipeline
// Field widths, intermediate widths, register indexes and the plane bundle.
// ----------------------------------------------------------------------------
package obbp_pkg;

  // Field widths
  localparam int CompW  = 16;   // Q1.14 component
  localparam int CoordW = 32;   // Q16.16 coordinate
  localparam int HalfW  = 31;   // Q15.16 unsigned half extent
  localparam int AxisW  = 3 * CompW;
  localparam int GapW   = 40;   // Q24.16 result
  localparam int CfgW   = 32;

  // Intermediate widths
  localparam int NProdW = 2 * CompW;        // component by normal product
  localparam int RnW    = NProdW + 1;       // rotated normal, Q.28
  localparam int MagW   = RnW - 1;          // |rotated normal|
  localparam int DProdW = CompW + CoordW;   // normal by centre product
  localparam int DSumW  = DProdW + 1;       // d before scaling, Q.30
  localparam int DFracShift = 14;
  localparam int RFracShift = 28;
  localparam int DW     = DSumW - DFracShift + 1;  // d after offset, Q.16
  localparam int TermW  = HalfW + MagW - RFracShift;
  localparam int RW     = TermW + 2;        // sum of three terms

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NORMAL_X     = 2'd0,
    CFG_NORMAL_Y     = 2'd1,
    CFG_NORMAL_Z     = 2'd2,
    CFG_PLANE_OFFSET = 2'd3
  } cfg_idx_t;

  localparam logic signed [CompW-1:0] NORMAL_Z_RST = 16'sd16384;

  // Plane as held in configuration
  typedef struct packed {
    logic signed [CompW-1:0]  nx;
    logic signed [CompW-1:0]  ny;
    logic signed [CompW-1:0]  nz;
    logic signed [CoordW-1:0] off;
  } plane_t;

  typedef logic [2:0][MagW-1:0]  mag_vec_t;
  typedef logic [2:0][HalfW-1:0] half_vec_t;
  typedef logic [2:0][AxisW-1:0] axis_vec_t;

endpackage

// ===== rtl/obbp_rot.sv =====
// ----------------------------------------------------------------------------
// obbp_rot: rotate the plane normal into box space
// Stage 1 forms the nine component products, stage 2 sums each column and
// takes the magnitude. Half extents travel alongside.
// ----------------------------------------------------------------------------
module obbp_rot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  obbp_pkg::plane_t   plane,
  input  obbp_pkg::axis_vec_t axis,
  input  obbp_pkg::half_vec_t half_in,
  output logic               out_valid,
  output obbp_pkg::mag_vec_t mag,
  output obbp_pkg::half_vec_t half_out
);
  import obbp_pkg::*;

  logic signed [CompW-1:0]  nrm [3];
  logic signed [NProdW-1:0] prod_nxt [3][3];
  logic signed [NProdW-1:0] prod_r   [3][3];
  logic signed [RnW-1:0]    rn       [3];
  mag_vec_t                 mag_nxt;
  mag_vec_t                 mag_r;
  half_vec_t                half1_r;
  half_vec_t                half2_r;
  logic                     vld1_r;
  logic                     vld2_r;

  assign nrm[0] = plane.nx;
  assign nrm[1] = plane.ny;
  assign nrm[2] = plane.nz;

  // Stage 1: column component times normal component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed(axis[i][CompW*j +: CompW]) * nrm[j];
      end
    end
  end

  // Stage 2: column dot normal, then magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rn[i] = RnW'(prod_r[i][0]) + RnW'(prod_r[i][1]) + RnW'(prod_r[i][2]);
      mag_nxt[i] = rn[i][RnW-1] ? MagW'(-rn[i]) : MagW'(rn[i]);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    half1_r <= half_in;
    mag_r   <= mag_nxt;
    half2_r <= half1_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  assign out_valid = vld2_r;
  assign mag       = mag_r;
  assign half_out  = half2_r;

endmodule

// ===== rtl/obbp_rad.sv =====
// ----------------------------------------------------------------------------
// obbp_rad: projected radius of the box onto the plane normal
// Stage 3 scales each half extent by its rotated normal magnitude and floors
// to Q.16, stage 4 sums the three terms.
// ----------------------------------------------------------------------------
module obbp_rad (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  obbp_pkg::mag_vec_t  mag,
  input  obbp_pkg::half_vec_t half,
  output logic                out_valid,
  output logic [obbp_pkg::RW-1:0] radius
);
  import obbp_pkg::*;

  logic [HalfW+MagW-1:0] full [3];
  logic [TermW-1:0]      term_nxt [3];
  logic [TermW-1:0]      term_r   [3];
  logic [RW-1:0]         rad_nxt;
  logic [RW-1:0]         rad_r;
  logic                  vld3_r;
  logic                  vld4_r;

  // Stage 3: one 31x32 product per axis, floored to Q.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i]     = (HalfW+MagW)'(half[i]) * (HalfW+MagW)'(mag[i]);
      term_nxt[i] = full[i][HalfW+MagW-1:RFracShift];
    end
  end

  // Stage 4: radius sum
  assign rad_nxt = RW'(term_r[0]) + RW'(term_r[1]) + RW'(term_r[2]);

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    rad_r  <= rad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld3_r <= in_valid;
      vld4_r <= vld3_r;
    end
  end

  assign out_valid = vld4_r;
  assign radius    = rad_r;

endmodule

// ===== rtl/obbp_dist.sv =====
// ----------------------------------------------------------------------------
// obbp_dist: signed distance of the box centre from the plane
// Four stages matched to the radius path: products, sum, floor and offset,
// then a delay stage to line up with the radius sum.
// ----------------------------------------------------------------------------
module obbp_dist (
  input  logic                           clk,
  input  obbp_pkg::plane_t               plane,
  input  logic signed [obbp_pkg::CoordW-1:0] center_x,
  input  logic signed [obbp_pkg::CoordW-1:0] center_y,
  input  logic signed [obbp_pkg::CoordW-1:0] center_z,
  output logic signed [obbp_pkg::DW-1:0] d_out
);
  import obbp_pkg::*;

  logic signed [DProdW-1:0] dprod_r [3];
  logic signed [DSumW-1:0]  dsum_nxt;
  logic signed [DSumW-1:0]  dsum_r;
  logic signed [DW-1:0]     d_nxt;
  logic signed [DW-1:0]     d3_r;
  logic signed [DW-1:0]     d4_r;

  // Stage 2 sum; stage 3 floors Q.30 to Q.16 and removes the offset
  assign dsum_nxt = DSumW'(dprod_r[0]) + DSumW'(dprod_r[1]) + DSumW'(dprod_r[2]);
  assign d_nxt    = DW'(dsum_r >>> DFracShift) - DW'(plane.off);

  always_ff @(posedge clk) begin
    dprod_r[0] <= center_x * plane.nx;
    dprod_r[1] <= center_y * plane.ny;
    dprod_r[2] <= center_z * plane.nz;
    dsum_r     <= dsum_nxt;
    d3_r       <= d_nxt;
    d4_r       <= d3_r;
  end

  assign d_out = d4_r;

endmodule

// ===== rtl/obb_plane_signed_gap.sv =====
// ----------------------------------------------------------------------------
// obb_plane_signed_gap: signed gap between an oriented box and a plane
// Pipeline: five register stages, from start taken to the result strobe.
// Throughput: one box per cycle, busy stays low, set by the five-stage
// multiply/add pipeline. The receiver cannot stall.
// Reset: synchronous, clears the valid bits and loads the plane registers
// with normal (0, 0, 1.0) and offset 0.
// ----------------------------------------------------------------------------
module obb_plane_signed_gap (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transfer
  input  logic                                start,
  output logic                                busy,
  input  logic signed [obbp_pkg::CoordW-1:0]  in_center_x,
  input  logic signed [obbp_pkg::CoordW-1:0]  in_center_y,
  input  logic signed [obbp_pkg::CoordW-1:0]  in_center_z,
  input  logic [obbp_pkg::HalfW-1:0]          in_half_x,
  input  logic [obbp_pkg::HalfW-1:0]          in_half_y,
  input  logic [obbp_pkg::HalfW-1:0]          in_half_z,
  input  logic [obbp_pkg::AxisW-1:0]          in_axis_col0,
  input  logic [obbp_pkg::AxisW-1:0]          in_axis_col1,
  input  logic [obbp_pkg::AxisW-1:0]          in_axis_col2,
  // result transfer
  output logic                                out_valid,
  output logic signed [obbp_pkg::GapW-1:0]    out_gap,
  // configuration
  input  logic                                cfg_we,
  input  obbp_pkg::cfg_idx_t                  cfg_index,
  input  logic [obbp_pkg::CfgW-1:0]           cfg_data
);
  import obbp_pkg::*;

  logic signed [CompW-1:0]  nx_r;
  logic signed [CompW-1:0]  ny_r;
  logic signed [CompW-1:0]  nz_r;
  logic signed [CoordW-1:0] off_r;
  plane_t                   plane;
  logic                     in_xfer;
  axis_vec_t                axis;
  half_vec_t                half_in;
  logic                     rot_vld;
  mag_vec_t                 mag;
  half_vec_t                half2;
  logic                     rad_vld;
  logic [RW-1:0]            radius;
  logic signed [DW-1:0]     d_ctr;
  logic [DW-1:0]            abs_d;
  logic                     crossing;
  logic signed [GapW-1:0]   gap_nxt;
  logic signed [GapW-1:0]   gap_r;
  logic                     vld5_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= NORMAL_Z_RST;
      off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORMAL_X:     nx_r  <= cfg_data[CompW-1:0];
        CFG_NORMAL_Y:     ny_r  <= cfg_data[CompW-1:0];
        CFG_NORMAL_Z:     nz_r  <= cfg_data[CompW-1:0];
        CFG_PLANE_OFFSET: off_r <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  assign plane = '{nx: nx_r, ny: ny_r, nz: nz_r, off: off_r};

  // Fully pipelined, a transfer is taken every cycle
  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  assign axis    = {in_axis_col2, in_axis_col1, in_axis_col0};
  assign half_in = {in_half_z, in_half_y, in_half_x};

  obbp_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_xfer),
    .plane     (plane),
    .axis      (axis),
    .half_in   (half_in),
    .out_valid (rot_vld),
    .mag       (mag),
    .half_out  (half2)
  );

  obbp_rad u_rad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_vld),
    .mag       (mag),
    .half      (half2),
    .out_valid (rad_vld),
    .radius    (radius)
  );

  obbp_dist u_dist (
    .clk      (clk),
    .plane    (plane),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .center_z (in_center_z),
    .d_out    (d_ctr)
  );

  // Stage 5: crossing test and gap select; tangent counts as not crossing
  always_comb begin
    abs_d    = d_ctr[DW-1] ? DW'(-d_ctr) : DW'(d_ctr);
    crossing = RW'(abs_d) < radius;
    if (crossing) begin
      gap_nxt = '0;
    end else if (d_ctr[DW-1]) begin
      gap_nxt = GapW'(d_ctr) + GapW'(radius);
    end else begin
      gap_nxt = GapW'(d_ctr) - GapW'(radius);
    end
  end

  always_ff @(posedge clk) begin
    gap_r <= gap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= rad_vld;
    end
  end

  assign out_valid = vld5_r;
  assign out_gap   = gap_r;

endmodule
